@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the list table RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define BOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition holds on every rising clock edge outside reset.
`define BOL_ALWAYS(lbl, cond, msg) \
  `BOL_ASSERT(lbl, (cond), msg)

`endif

@@ rtl/bol_pkg.sv @@
// ---------------------------------------------------------------------------
// bol_pkg
// Types and constants shared by the bounded ordered list table and its cells.
// ---------------------------------------------------------------------------
package bol_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MODE_W = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [MODE_W-1:0] MD_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MD_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MD_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MD_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MD_INSERT     = 3'd4;
  localparam logic [MODE_W-1:0] MD_ERASE      = 3'd5;
  localparam logic [MODE_W-1:0] MD_READ       = 3'd6;

  typedef enum logic [STAT_W-1:0] {
    SC_OK    = 2'd0,
    SC_EMPTY = 2'd1,
    SC_FULL  = 2'd2,
    SC_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_t;

  typedef enum logic [1:0] {
    CK_HOLD,
    CK_INS,
    CK_DEL
  } cmd_kind_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  rpos;
    logic [VAL_W-1:0]  value;
  } cmd_t;

endpackage

@@ rtl/bol_cell.sv @@
// ---------------------------------------------------------------------------
// bol_cell
// One entry of the list: loads, shifts from a neighbour or holds, and offers
// its value on two select taps.
// ---------------------------------------------------------------------------
module bol_cell (
  input  logic                      clk,
  input  logic [bol_pkg::IDX_W-1:0] idx,
  input  bol_pkg::cmd_t             cmd,
  input  logic [bol_pkg::IDX_W-1:0] tail_idx,
  input  logic [bol_pkg::VAL_W-1:0] left_data,
  input  logic [bol_pkg::VAL_W-1:0] right_data,
  output logic [bol_pkg::VAL_W-1:0] data,
  output logic [bol_pkg::VAL_W-1:0] read_tap,
  output logic [bol_pkg::VAL_W-1:0] tail_tap
);
  import bol_pkg::*;

  logic [VAL_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.kind)
      CK_INS: begin
        if (idx == cmd.pos) begin
          data_next = cmd.value;
        end else if (idx > cmd.pos) begin
          data_next = left_data;
        end
      end
      CK_DEL: begin
        if (idx >= cmd.pos) begin
          data_next = right_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign read_tap = (idx == cmd.rpos) ? data : '0;
  assign tail_tap = (idx == tail_idx) ? data : '0;

endmodule

@@ rtl/bounded_ordered_list_table.sv @@
// ---------------------------------------------------------------------------
// bounded_ordered_list_table
// Bounded ordered list of signed values held in a row of shifting cells,
// with push and pop at both ends, indexed insert, erase and read.
// ---------------------------------------------------------------------------
//  Channel   Handshake        Ports
//  command   start / busy     mode, position, value
//  result    done strobe      result_value, status, occupancy, head_value,
//                             tail_value
//
// For each item, the cell row shifts at the accepting edge, then
// busy stays high for one cycle while the front and back are gathered from
// the row. The result strobe comes in the cycle after, when the next item may
// already be accepted. Reset clears the occupancy and the control state; cell
// contents are left as they are. Results cannot be stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_ordered_list_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bol_pkg::MODE_W-1:0]        mode,
  input  logic [bol_pkg::POS_W-1:0]         position,
  input  logic signed [bol_pkg::VAL_W-1:0]  value,
  output logic                              done,
  output logic signed [bol_pkg::VAL_W-1:0]  result_value,
  output logic [bol_pkg::STAT_W-1:0]        status,
  output logic [bol_pkg::POS_W-1:0]         occupancy,
  output logic signed [bol_pkg::VAL_W-1:0]  head_value,
  output logic signed [bol_pkg::VAL_W-1:0]  tail_value
);
  import bol_pkg::*;

  state_t           st;
  state_t           st_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  status_t          status_q;
  status_t          status_next;
  logic [VAL_W-1:0] res_q;
  logic [VAL_W-1:0] res_next;
  logic             accept;
  logic             take_res;
  cmd_t             cmd;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             is_full;
  logic             list_empty;
  logic [IDX_W-1:0] last_idx;
  logic [VAL_W-1:0] read_val;
  logic [VAL_W-1:0] tail_val;

  logic [VAL_W-1:0] cell_data [DEPTH];
  logic [VAL_W-1:0] read_taps [DEPTH];
  logic [VAL_W-1:0] tail_taps [DEPTH];

  assign busy       = (st == ST_REPORT);
  assign accept     = start && !busy;
  assign pos_ext    = CMP_W'(position);
  assign cnt_ext    = CMP_W'(count);
  assign is_full    = (count == CNT_W'(DEPTH));
  assign list_empty = (count == '0);
  assign last_idx   = IDX_W'(count - CNT_W'(1));

  // Decode one item into a row command, a status and the new occupancy.
  always_comb begin
    cmd.kind    = CK_HOLD;
    cmd.pos     = '0;
    cmd.rpos    = '0;
    cmd.value   = value;
    status_next = SC_OK;
    count_next  = count;
    take_res    = 1'b0;
    case (mode)
      MD_PUSH_FRONT: begin
        if (is_full) begin
          status_next = SC_FULL;
        end else begin
          cmd.kind   = CK_INS;
          count_next = count + CNT_W'(1);
        end
      end
      MD_PUSH_BACK: begin
        if (is_full) begin
          status_next = SC_FULL;
        end else begin
          cmd.kind   = CK_INS;
          cmd.pos    = IDX_W'(count);
          count_next = count + CNT_W'(1);
        end
      end
      MD_POP_FRONT: begin
        if (list_empty) begin
          status_next = SC_EMPTY;
        end else begin
          cmd.kind   = CK_DEL;
          take_res   = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      MD_POP_BACK: begin
        if (list_empty) begin
          status_next = SC_EMPTY;
        end else begin
          cmd.rpos   = last_idx;
          take_res   = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      MD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_next = SC_RANGE;
        end else if (is_full) begin
          status_next = SC_FULL;
        end else begin
          cmd.kind   = CK_INS;
          cmd.pos    = IDX_W'(position);
          count_next = count + CNT_W'(1);
        end
      end
      MD_ERASE: begin
        if (list_empty) begin
          status_next = SC_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_next = SC_RANGE;
        end else begin
          cmd.kind   = CK_DEL;
          cmd.pos    = IDX_W'(position);
          cmd.rpos   = IDX_W'(position);
          take_res   = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      MD_READ: begin
        if (list_empty) begin
          status_next = SC_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_next = SC_RANGE;
        end else begin
          cmd.rpos = IDX_W'(position);
          take_res = 1'b1;
        end
      end
      default: begin
        status_next = SC_OK;
      end
    endcase
    if (!accept) begin
      cmd.kind = CK_HOLD;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [VAL_W-1:0] left_in;
      logic [VAL_W-1:0] right_in;
      if (gi == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_mid_l
        assign left_in = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_in = '0;
      end else begin : g_mid_r
        assign right_in = cell_data[gi+1];
      end
      bol_cell u_cell (
        .clk        (clk),
        .idx        (IDX_W'(gi)),
        .cmd        (cmd),
        .tail_idx   (last_idx),
        .left_data  (left_in),
        .right_data (right_in),
        .data       (cell_data[gi]),
        .read_tap   (read_taps[gi]),
        .tail_tap   (tail_taps[gi])
      );
    end
  endgenerate

  // Only the selected cell drives a non-zero tap, so an OR gathers it.
  always_comb begin
    read_val = '0;
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_val = read_val | read_taps[i];
      tail_val = tail_val | tail_taps[i];
    end
  end

  assign res_next = take_res ? read_val : '0;

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (start) begin
          st_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        st_next = ST_IDLE;
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      st   <= st_next;
      done <= (st == ST_REPORT);
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      res_q    <= res_next;
    end
    if (st == ST_REPORT) begin
      result_value <= res_q;
      status       <= status_q;
      occupancy    <= POS_W'(count);
      head_value   <= list_empty ? '0 : cell_data[0];
      tail_value   <= list_empty ? '0 : tail_val;
    end
  end

  `BOL_ASSERT(a_done_after_report, (st == ST_REPORT) |=> done, "result strobe missing after report cycle")
  `BOL_ASSERT(a_ins_grows, (accept && cmd.kind == CK_INS) |=> (count == $past(count) + CNT_W'(1)), "insert did not grow the list")
  `BOL_ASSERT(a_full_only_at_depth, (accept && status_next == SC_FULL) |-> is_full, "full status on a list with room")
  `BOL_ASSERT(a_empty_zero_ends, (st == ST_REPORT && list_empty) |=> (head_value == '0 && tail_value == '0), "non-zero ends on an empty list")
  `BOL_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "occupancy beyond depth")

endmodule
